// ----- sv/rgbm_pkg.sv -----
// rgbm_pkg: shared types, register indexes and window reduction functions
// for the 3x3 RGB morphology filter. No dependencies.
`default_nettype none

package rgbm_pkg;

    localparam int CHAN_W = 8;
    localparam int PIX_W  = 3 * CHAN_W;
    localparam int LINE_W = 2 * PIX_W;   // {prev_prev_line, prev_line}

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [2:0][2:0][PIX_W-1:0] win_t;   // [row][col], row 2 / col 2 newest

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_OP_MODE = 2'd0;
    localparam logic [1:0] REG_WIDTH   = 2'd1;
    localparam logic [1:0] REG_HEIGHT  = 2'd2;

    localparam logic OP_ERODE  = 1'b0;
    localparam logic OP_DILATE = 1'b1;

    function automatic pixel_t pix_min(input pixel_t a, input pixel_t b);
        pixel_t res;
        for (int s = 0; s < 3; s++) begin
            res[s*CHAN_W +: CHAN_W] = (a[s*CHAN_W +: CHAN_W] < b[s*CHAN_W +: CHAN_W]) ?
                                      a[s*CHAN_W +: CHAN_W] : b[s*CHAN_W +: CHAN_W];
        end
        return res;
    endfunction

    function automatic pixel_t pix_max(input pixel_t a, input pixel_t b);
        pixel_t res;
        for (int s = 0; s < 3; s++) begin
            res[s*CHAN_W +: CHAN_W] = (a[s*CHAN_W +: CHAN_W] > b[s*CHAN_W +: CHAN_W]) ?
                                      a[s*CHAN_W +: CHAN_W] : b[s*CHAN_W +: CHAN_W];
        end
        return res;
    endfunction

    // Maximum over the whole window: row maxima, then across rows.
    function automatic pixel_t win_max(input win_t w);
        pixel_t rm [3];
        for (int k = 0; k < 3; k++) begin
            rm[k] = pix_max(pix_max(w[k][0], w[k][1]), w[k][2]);
        end
        return pix_max(pix_max(rm[0], rm[1]), rm[2]);
    endfunction

    // Minimum over the lower-right part of the window from row ks and column ms on.
    // Entries outside that part read as all ones and drop out of the minimum.
    function automatic pixel_t win_min(input win_t w, input logic [1:0] ks,
                                       input logic [1:0] ms);
        pixel_t e  [3][3];
        pixel_t rm [3];
        for (int k = 0; k < 3; k++) begin
            for (int m = 0; m < 3; m++) begin
                e[k][m] = (2'(k) >= ks && 2'(m) >= ms) ? w[k][m] : '1;
            end
        end
        for (int k = 0; k < 3; k++) begin
            rm[k] = pix_min(pix_min(e[k][0], e[k][1]), e[k][2]);
        end
        return pix_min(pix_min(rm[0], rm[1]), rm[2]);
    endfunction

endpackage

`default_nettype wire

// ----- sv/rgbm_line_buf.sv -----
// rgbm_line_buf: line memory holding the two previous rows, one entry per column.
// Registered read with write-to-read forwarding. Depends on rgbm_pkg.
`default_nettype none

module rgbm_line_buf #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                       aclk,
    input  wire logic                       rd_en,
    input  wire logic [AW-1:0]              rd_addr,
    output      logic [rgbm_pkg::LINE_W-1:0] rd_data,
    input  wire logic                       wr_en,
    input  wire logic [AW-1:0]              wr_addr,
    input  wire logic [rgbm_pkg::LINE_W-1:0] wr_data
);
    import rgbm_pkg::*;

    logic [LINE_W-1:0] mem [DEPTH];
    logic [LINE_W-1:0] mem_q_reg;
    logic [LINE_W-1:0] fwd_data_reg;
    logic              fwd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // A read that meets a write to the same entry takes the new data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            fwd_reg      <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : mem_q_reg;

endmodule

`default_nettype wire

// ----- sv/rgb_morphology_3x3.sv -----
// rgb_morphology_3x3: streaming flat 3x3 erosion / dilation of 24-bit BGR pixels.
// Depends on rgbm_pkg and rgbm_line_buf.
`default_nettype none

// Pixels enter in raster order, one transaction per pixel, blue in the low byte.
// Each channel is filtered on its own with a flat 3x3 element; edges are clamped.
// Dilation (op_mode 1) returns one result per pixel, the maximum over rows i-2..i
// and columns j-2..j, and runs at one pixel per clock while the output is free. Erosion (op_mode 0)
// returns pixel (i,j), the minimum over rows i..i+2 and columns j..j+2, once
// pixel (min(i+2,H-1),min(j+2,W-1)) has arrived: no result for the first two
// rows and columns, up to three results for a pixel at the right edge and up
// to nine at the bottom-right corner, given in row-major order with tlast on
// the final one. Stage B presents one result at a time; the next pixel waits in
// stage A until the last result of the one before is out, and a pixel with no
// result leaves B empty. Otherwise the flow is one pixel per clock while the
// output is free. A pixel passes stage A (line-memory read) and stage B (window)
// on its way to the output register. Program op_mode, image_width and image_height
// only while idle; width is clamped to 1..MAX_WIDTH and height to 1..MAX_HEIGHT.
// out_row and out_col carry the low 12 and 10 bits of the emitted position.
module rgb_morphology_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready,
    // pixel input
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [23:0] s_tdata,   // in_blue[7:0], in_green[15:8], in_red[23:16]
    // result output
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [47:0] m_tdata,   // out_blue[7:0], out_green[15:8], out_red[23:16],
                                        // out_row[35:24], out_col[45:36], zero[47:46]
    output      logic        m_tlast    // last_of_run
);
    import rgbm_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam logic [CW:0] W_MAX = (CW+1)'(MAX_WIDTH);
    localparam logic [RW:0] H_MAX = (RW+1)'(MAX_HEIGHT);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        op_mode_reg;
    logic [10:0] cfg_width_reg;
    logic [12:0] cfg_height_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_mode_reg    <= OP_ERODE;
            cfg_width_reg  <= 11'd1024;
            cfg_height_reg <= 13'd1024;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_OP_MODE: op_mode_reg    <= pwdata[0];
                REG_WIDTH:   cfg_width_reg  <= pwdata[10:0];
                REG_HEIGHT:  cfg_height_reg <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_OP_MODE: prdata = {31'd0, op_mode_reg};
            REG_WIDTH:   prdata = {21'd0, cfg_width_reg};
            REG_HEIGHT:  prdata = {19'd0, cfg_height_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // Effective geometry, clamped to the supported range
    logic [CW:0] w_eff;
    logic [RW:0] h_eff;

    always_comb begin
        if (cfg_width_reg == '0) begin
            w_eff = (CW+1)'(1);
        end else if (32'(cfg_width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = W_MAX;
        end else begin
            w_eff = (CW+1)'(cfg_width_reg);
        end
        if (cfg_height_reg == '0) begin
            h_eff = (RW+1)'(1);
        end else if (32'(cfg_height_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = H_MAX;
        end else begin
            h_eff = (RW+1)'(cfg_height_reg);
        end
    end

    // ------------------------------------------------------------------
    // Raster position; saturate a counter left past the end of a shrunk frame
    // ------------------------------------------------------------------
    logic [CW-1:0] col_count_reg, col_count_next;
    logic [RW-1:0] row_count_reg, row_count_next;
    logic [CW-1:0] c_cur;
    logic [RW-1:0] r_cur;
    logic          c_last, r_last;
    logic          s_accept;

    always_comb begin
        c_cur  = ({1'b0, col_count_reg} < w_eff) ? col_count_reg
                                                 : CW'(w_eff - (CW+1)'(1));
        r_cur  = ({1'b0, row_count_reg} < h_eff) ? row_count_reg
                                                 : RW'(h_eff - (RW+1)'(1));
        c_last = ({1'b0, c_cur} == w_eff - (CW+1)'(1));
        r_last = ({1'b0, r_cur} == h_eff - (RW+1)'(1));
        if (c_last) begin
            col_count_next = '0;
            row_count_next = r_last ? '0 : r_cur + RW'(1);
        end else begin
            col_count_next = c_cur + CW'(1);
            row_count_next = r_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else if (s_accept) begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: pixel waits here while the line memory is read
    // ------------------------------------------------------------------
    logic          a_valid_reg;
    pixel_t        a_px_reg;
    logic [CW-1:0] a_c_reg;
    logic [RW-1:0] a_r_reg;
    logic          a_clast_reg, a_rlast_reg;
    logic          a_move;
    logic [LINE_W-1:0] line_rd;
    pixel_t        prev_px, prev_prev_px, mid_px, top_px;

    assign s_tready = !a_valid_reg || a_move;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_accept) begin
            a_valid_reg <= 1'b1;
        end else if (a_move) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_px_reg    <= s_tdata;
            a_c_reg     <= c_cur;
            a_r_reg     <= r_cur;
            a_clast_reg <= c_last;
            a_rlast_reg <= r_last;
        end
    end

    // Read the column's history on accept; push this pixel into it when A advances.
    rgbm_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (c_cur),
        .rd_data (line_rd),
        .wr_en   (a_move),
        .wr_addr (a_c_reg),
        .wr_data ({prev_px, a_px_reg})
    );

    // Replicate the current row upward at the top of the frame.
    always_comb begin
        prev_px      = line_rd[PIX_W-1:0];
        prev_prev_px = line_rd[LINE_W-1:PIX_W];
        mid_px       = (a_r_reg >= RW'(1)) ? prev_px : a_px_reg;
        top_px       = (a_r_reg >= RW'(2)) ? prev_prev_px : mid_px;
    end

    // ------------------------------------------------------------------
    // Stage B: 3x3 window and result enumeration
    // ------------------------------------------------------------------
    win_t          win_reg;
    logic          b_valid_reg;
    logic          b_dil_reg;
    logic [CW-1:0] b_c_reg;
    logic [RW-1:0] b_r_reg;
    logic [1:0]    b_k_reg, b_m_reg, b_m0_reg, b_kend_reg, b_mend_reg;
    logic          b_last, b_emit, b_done, out_free;

    // Result range of the arriving pixel, as window row/column offsets
    logic [1:0]    n_k0, n_m0, n_kend, n_mend;
    logic          n_ok;

    always_comb begin
        n_ok = (a_rlast_reg || a_r_reg >= RW'(2)) && (a_clast_reg || a_c_reg >= CW'(2));
        if (op_mode_reg == OP_DILATE) begin
            n_k0 = 2'd2; n_kend = 2'd2;
            n_m0 = 2'd2; n_mend = 2'd2;
        end else begin
            if (a_rlast_reg) begin
                n_kend = 2'd2;
                n_k0   = (a_r_reg >= RW'(2)) ? 2'd0 : 2'd2 - 2'(a_r_reg);
            end else begin
                n_kend = 2'd0;
                n_k0   = 2'd0;
            end
            if (a_clast_reg) begin
                n_mend = 2'd2;
                n_m0   = (a_c_reg >= CW'(2)) ? 2'd0 : 2'd2 - 2'(a_c_reg);
            end else begin
                n_mend = 2'd0;
                n_m0   = 2'd0;
            end
        end
    end

    assign out_free = !m_tvalid || m_tready;
    assign b_last   = (b_k_reg == b_kend_reg) && (b_m_reg == b_mend_reg);
    assign b_emit   = b_valid_reg && out_free;
    assign b_done   = b_emit && b_last;
    assign a_move   = a_valid_reg && (!b_valid_reg || b_done);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (a_move) begin
            // an erosion pixel that completes no output window leaves B empty
            b_valid_reg <= (op_mode_reg == OP_DILATE) || n_ok;
        end else if (b_done) begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_move) begin
            // start of row: fill the window with the new column; else shift left
            if (a_c_reg == '0) begin
                for (int m = 0; m < 3; m++) begin
                    win_reg[0][m] <= top_px;
                    win_reg[1][m] <= mid_px;
                    win_reg[2][m] <= a_px_reg;
                end
            end else begin
                for (int k = 0; k < 3; k++) begin
                    win_reg[k][0] <= win_reg[k][1];
                    win_reg[k][1] <= win_reg[k][2];
                end
                win_reg[0][2] <= top_px;
                win_reg[1][2] <= mid_px;
                win_reg[2][2] <= a_px_reg;
            end
            b_dil_reg  <= (op_mode_reg == OP_DILATE);
            b_c_reg    <= a_c_reg;
            b_r_reg    <= a_r_reg;
            b_k_reg    <= n_k0;
            b_m_reg    <= n_m0;
            b_m0_reg   <= n_m0;
            b_kend_reg <= n_kend;
            b_mend_reg <= n_mend;
        end else if (b_emit && !b_last) begin
            // row-major walk over the released results
            if (b_m_reg == b_mend_reg) begin
                b_k_reg <= b_k_reg + 2'd1;
                b_m_reg <= b_m0_reg;
            end else begin
                b_m_reg <= b_m_reg + 2'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    pixel_t        res_px;
    logic [RW-1:0] res_row;
    logic [CW-1:0] res_col;

    always_comb begin
        res_px  = b_dil_reg ? win_max(win_reg) : win_min(win_reg, b_k_reg, b_m_reg);
        res_row = b_r_reg + RW'(b_k_reg) - RW'(2);
        res_col = b_c_reg + CW'(b_m_reg) - CW'(2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (b_emit) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_emit) begin
            m_tdata <= {2'b00, 10'(32'(res_col)), 12'(32'(res_row)), res_px};
            m_tlast <= b_last;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The result walk never runs past the end of the released range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg |-> (b_k_reg <= b_kend_reg) && (b_m_reg <= b_mend_reg))
        else $error("result walk beyond released range");

    // Dilation releases exactly one result, at the pixel's own position.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && b_dil_reg) |-> b_last)
        else $error("dilation item with more than one result");

    // A stalled pixel in stage A keeps its position.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && !a_move) |=> (a_valid_reg && $stable(a_c_reg) && $stable(a_r_reg)))
        else $error("stage A lost or changed a stalled pixel");

    // Every emitted result reaches the output register in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        b_emit |=> m_tvalid)
        else $error("emitted result not presented");

endmodule

`default_nettype wire
